// File: sv/gclp_pkg.sv
// Package for the G-code line field parser: widths, character codes, slot codes,
// the parse phase enum and the structs passed between the pipeline modules.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package gclp_pkg;

	localparam int MAX_WORDS       = 5;
	localparam int FRAC_BITS       = 16;
	localparam int MAX_FRAC_DIGITS = 5;

	localparam int CHAR_W  = 8;
	localparam int ACC_W   = 48;
	localparam int ACCX_W  = ACC_W + 4;
	localparam int VAL_W   = 32;
	localparam int CMD_W   = 16;
	localparam int MASK_W  = 4;
	localparam int NSLOT   = 6;
	localparam int SLOT_W  = 3;
	localparam int FRAC_W  = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int WCNT_W  = $clog2(MAX_WORDS + 1);
	localparam int P_W     = $clog2(10 ** MAX_FRAC_DIGITS + 1);
	localparam int NUM_W   = ACC_W + FRAC_BITS;
	localparam int REM_W   = P_W + VAL_W;
	localparam int DIV_STAGES = 8;
	localparam int BPS        = VAL_W / DIV_STAGES;
	localparam int RES_DEPTH  = 2;
	localparam int RES_AW     = $clog2(RES_DEPTH);
	localparam int RES_CW     = $clog2(RES_DEPTH + 1);

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [ACCX_W-1:0] accx_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [MASK_W-1:0] mask_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [WCNT_W:0]   wcnt_x_t;
	typedef logic [WCNT_W-1:0] wcnt_t;
	typedef logic [P_W-1:0]    pow_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [RES_CW-1:0] rcnt_t;

	localparam acc_t ACC_CAP = (acc_t'(1) << (ACC_W - 1)) - acc_t'(1);
	localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam cmd_t CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
	localparam cmd_t CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};

	localparam char_t CH_G     = "G";
	localparam char_t CH_M     = "M";
	localparam char_t CH_H     = "H";
	localparam char_t CH_X     = "X";
	localparam char_t CH_Y     = "Y";
	localparam char_t CH_Z     = "Z";
	localparam char_t CH_E     = "E";
	localparam char_t CH_F     = "F";
	localparam char_t CH_T     = "T";
	localparam char_t CH_SP    = " ";
	localparam char_t CH_LF    = 8'h0A;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_PLUS  = "+";
	localparam char_t CH_MINUS = "-";
	localparam char_t CH_DOT   = ".";
	localparam char_t CH_0     = "0";
	localparam char_t CH_9     = "9";

	localparam logic [1:0] LET_G = 2'd0;
	localparam logic [1:0] LET_M = 2'd1;
	localparam logic [1:0] LET_H = 2'd2;

	localparam slot_t SLOT_X   = 3'd0;
	localparam slot_t SLOT_Y   = 3'd1;
	localparam slot_t SLOT_Z   = 3'd2;
	localparam slot_t SLOT_E   = 3'd3;
	localparam slot_t SLOT_F   = 3'd4;
	localparam slot_t SLOT_T   = 3'd5;
	localparam slot_t SLOT_CMD = 3'd6;

	typedef enum logic [2:0] {
		PH_LINE_START,
		PH_NUM_BEGIN,
		PH_NUM_INT,
		PH_NUM_FRAC,
		PH_NUM_JUNK,
		PH_WORD_START,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic       vld;
		logic       commit;
		logic       eol;
		slot_t      slot;
		acc_t       accum;
		frac_t      frac;
		logic       neg;
		logic       letter_ok;
		logic [1:0] letter_code;
	} ev_t;

	typedef struct packed {
		logic       vld;
		logic       commit;
		logic       eol;
		slot_t      slot;
		logic       neg;
		logic       sat;
		cmd_t       cmd;
		rem_t       rem;
		val_t       quo;
		pow_t       p;
		logic       letter_ok;
		logic [1:0] letter_code;
	} div_t;

	typedef struct packed {
		logic       accepted;
		logic [1:0] cmd_letter;
		cmd_t       cmd_number;
		mask_t      given_mask;
		val_t       x_value;
		val_t       y_value;
		val_t       z_value;
		val_t       e_value;
		val_t       feed_value;
		val_t       tool_value;
	} res_t;

	function automatic pow_t pow10(input frac_t f);
		pow_t r;
		r = pow_t'(1);
		for (int i = 1; i <= MAX_FRAC_DIGITS; i++) begin
			if (frac_t'(i) == f) begin
				r = pow_t'(10 ** i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/gclp_if.sv
// Handshake channels of the G-code line field parser: the character channel
// and the result channel. Depends on gclp_pkg for the field widths.
`default_nettype none

interface gclp_char_if;
	logic                               valid;
	logic                               ready;
	logic [gclp_pkg::CHAR_W-1:0]        character;

	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface gclp_res_if;
	logic                               valid;
	logic                               ready;
	logic                               accepted;
	logic [1:0]                         cmd_letter;
	logic signed [gclp_pkg::CMD_W-1:0]  cmd_number;
	logic [gclp_pkg::MASK_W-1:0]        given_mask;
	logic signed [gclp_pkg::VAL_W-1:0]  x_value;
	logic signed [gclp_pkg::VAL_W-1:0]  y_value;
	logic signed [gclp_pkg::VAL_W-1:0]  z_value;
	logic signed [gclp_pkg::VAL_W-1:0]  e_value;
	logic signed [gclp_pkg::VAL_W-1:0]  feed_value;
	logic signed [gclp_pkg::VAL_W-1:0]  tool_value;

	modport source (output valid, output accepted, output cmd_letter, output cmd_number,
		output given_mask, output x_value, output y_value, output z_value, output e_value,
		output feed_value, output tool_value, input ready);
	modport sink (input valid, input accepted, input cmd_letter, input cmd_number,
		input given_mask, input x_value, input y_value, input z_value, input e_value,
		input feed_value, input tool_value, output ready);
endinterface

`default_nettype wire

// File: sv/gclp_parser.sv
// Character parser: the line state machine and the decimal digit accumulator.
// Emits one event per completed number or end of a non-empty line. Depends on gclp_pkg, gclp_if.
`default_nettype none

module gclp_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	gclp_char_if.sink          chr,
	input  wire logic          adv,
	output gclp_pkg::ev_t      ev_s1
);

	gclp_pkg::phase_t  phase_q, phase_d;
	logic              nonempty_q, nonempty_d;
	logic [1:0]        letter_code_q, letter_code_d;
	logic              letter_ok_q, letter_ok_d;
	gclp_pkg::wcnt_t   wcnt_q, wcnt_d;
	gclp_pkg::slot_t   cur_q, cur_d;
	gclp_pkg::acc_t    acc_q, acc_d;
	gclp_pkg::frac_t   frac_q, frac_d;
	logic              neg_q, neg_d;

	gclp_pkg::char_t   c;
	logic              accept;
	logic              is_term;
	logic              is_digit;
	logic              in_num;
	logic              commit;
	logic [3:0]        dval;
	gclp_pkg::accx_t   acc_x10;
	gclp_pkg::acc_t    acc_inc;
	gclp_pkg::slot_t   word_slot;
	logic              word_hit;
	gclp_pkg::ev_t     ev_d;

	assign chr.ready = adv;
	assign accept    = chr.valid & adv;
	assign c         = chr.character;
	assign is_term   = (c == gclp_pkg::CH_LF) || (c == gclp_pkg::CH_CR);
	assign is_digit  = (c >= gclp_pkg::CH_0) && (c <= gclp_pkg::CH_9);
	assign in_num    = (phase_q == gclp_pkg::PH_NUM_BEGIN) || (phase_q == gclp_pkg::PH_NUM_INT) ||
		(phase_q == gclp_pkg::PH_NUM_FRAC) || (phase_q == gclp_pkg::PH_NUM_JUNK);
	assign commit    = accept && in_num && (is_term || (c == gclp_pkg::CH_SP));
	assign dval      = 4'(c - gclp_pkg::CH_0);

	// Multiply by ten as two shifts and an add, saturating at the accumulator cap.
	assign acc_x10 = (gclp_pkg::accx_t'(acc_q) << 3) + (gclp_pkg::accx_t'(acc_q) << 1) +
		gclp_pkg::accx_t'(dval);
	assign acc_inc = (acc_x10 > gclp_pkg::accx_t'(gclp_pkg::ACC_CAP)) ? gclp_pkg::ACC_CAP :
		acc_x10[gclp_pkg::ACC_W-1:0];

	always_comb begin
		word_hit  = 1'b1;
		word_slot = gclp_pkg::SLOT_X;
		unique case (c)
			gclp_pkg::CH_X: word_slot = gclp_pkg::SLOT_X;
			gclp_pkg::CH_Y: word_slot = gclp_pkg::SLOT_Y;
			gclp_pkg::CH_Z: word_slot = gclp_pkg::SLOT_Z;
			gclp_pkg::CH_E: word_slot = gclp_pkg::SLOT_E;
			gclp_pkg::CH_F: word_slot = gclp_pkg::SLOT_F;
			gclp_pkg::CH_T: word_slot = gclp_pkg::SLOT_T;
			default: word_hit = 1'b0;
		endcase
	end

	always_comb begin
		phase_d       = phase_q;
		nonempty_d    = nonempty_q;
		letter_code_d = letter_code_q;
		letter_ok_d   = letter_ok_q;
		wcnt_d        = wcnt_q;
		cur_d         = cur_q;
		acc_d         = acc_q;
		frac_d        = frac_q;
		neg_d         = neg_q;
		if (accept) begin
			if (is_term) begin
				phase_d       = gclp_pkg::PH_LINE_START;
				nonempty_d    = 1'b0;
				letter_code_d = gclp_pkg::LET_G;
				letter_ok_d   = 1'b0;
				wcnt_d        = '0;
				cur_d         = gclp_pkg::SLOT_X;
				acc_d         = '0;
				frac_d        = '0;
				neg_d         = 1'b0;
			end else begin
				nonempty_d = 1'b1;
				unique case (phase_q)
					gclp_pkg::PH_LINE_START: begin
						if (c == gclp_pkg::CH_G || c == gclp_pkg::CH_M || c == gclp_pkg::CH_H) begin
							letter_ok_d   = 1'b1;
							letter_code_d = (c == gclp_pkg::CH_G) ? gclp_pkg::LET_G :
								(c == gclp_pkg::CH_M) ? gclp_pkg::LET_M : gclp_pkg::LET_H;
							cur_d   = gclp_pkg::SLOT_CMD;
							acc_d   = '0;
							frac_d  = '0;
							neg_d   = 1'b0;
							phase_d = gclp_pkg::PH_NUM_BEGIN;
						end else begin
							phase_d = gclp_pkg::PH_SKIP;
						end
					end
					gclp_pkg::PH_NUM_BEGIN, gclp_pkg::PH_NUM_INT,
					gclp_pkg::PH_NUM_FRAC, gclp_pkg::PH_NUM_JUNK: begin
						if (c == gclp_pkg::CH_SP) begin
							if (cur_q == gclp_pkg::SLOT_CMD) begin
								wcnt_d  = '0;
								phase_d = gclp_pkg::PH_WORD_START;
							end else if ((gclp_pkg::wcnt_x_t'(wcnt_q) + 1'b1) >=
								gclp_pkg::wcnt_x_t'(gclp_pkg::MAX_WORDS)) begin
								phase_d = gclp_pkg::PH_SKIP;
							end else begin
								wcnt_d  = wcnt_q + 1'b1;
								phase_d = gclp_pkg::PH_WORD_START;
							end
						end else if (phase_q == gclp_pkg::PH_NUM_FRAC) begin
							if (is_digit) begin
								if (frac_q < gclp_pkg::frac_t'(gclp_pkg::MAX_FRAC_DIGITS)) begin
									acc_d  = acc_inc;
									frac_d = frac_q + 1'b1;
								end
							end else begin
								phase_d = gclp_pkg::PH_NUM_JUNK;
							end
						end else if (phase_q != gclp_pkg::PH_NUM_JUNK) begin
							priority if (phase_q == gclp_pkg::PH_NUM_BEGIN &&
								(c == gclp_pkg::CH_PLUS || c == gclp_pkg::CH_MINUS)) begin
								neg_d   = (c == gclp_pkg::CH_MINUS);
								phase_d = gclp_pkg::PH_NUM_INT;
							end else if (is_digit) begin
								acc_d   = acc_inc;
								phase_d = gclp_pkg::PH_NUM_INT;
							end else if (c == gclp_pkg::CH_DOT && cur_q != gclp_pkg::SLOT_CMD) begin
								phase_d = gclp_pkg::PH_NUM_FRAC;
							end else begin
								phase_d = gclp_pkg::PH_NUM_JUNK;
							end
						end
					end
					gclp_pkg::PH_WORD_START: begin
						if (word_hit) begin
							cur_d   = word_slot;
							acc_d   = '0;
							frac_d  = '0;
							neg_d   = 1'b0;
							phase_d = gclp_pkg::PH_NUM_BEGIN;
						end else begin
							phase_d = gclp_pkg::PH_SKIP;
						end
					end
					gclp_pkg::PH_SKIP: begin
					end
					default: phase_d = gclp_pkg::PH_LINE_START;
				endcase
			end
		end
	end

	always_comb begin
		ev_d.vld         = commit || (accept && is_term && nonempty_q);
		ev_d.commit      = commit;
		ev_d.eol         = accept && is_term && nonempty_q;
		ev_d.slot        = cur_q;
		ev_d.accum       = acc_q;
		ev_d.frac        = frac_q;
		ev_d.neg         = neg_q;
		ev_d.letter_ok   = letter_ok_q;
		ev_d.letter_code = letter_code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= gclp_pkg::PH_LINE_START;
			nonempty_q    <= 1'b0;
			letter_code_q <= gclp_pkg::LET_G;
			letter_ok_q   <= 1'b0;
			wcnt_q        <= '0;
			cur_q         <= gclp_pkg::SLOT_X;
			acc_q         <= '0;
			frac_q        <= '0;
			neg_q         <= 1'b0;
			ev_s1         <= '0;
		end else begin
			phase_q       <= phase_d;
			nonempty_q    <= nonempty_d;
			letter_code_q <= letter_code_d;
			letter_ok_q   <= letter_ok_d;
			wcnt_q        <= wcnt_d;
			cur_q         <= cur_d;
			acc_q         <= acc_d;
			frac_q        <= frac_d;
			neg_q         <= neg_d;
			if (adv) begin
				ev_s1 <= ev_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/gclp_convert.sv
// Number conversion pipeline: decimal accumulator to saturated fixed point by a
// pipelined restoring division, plus command number saturation. Depends on gclp_pkg.
`default_nettype none

module gclp_convert (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  gclp_pkg::ev_t      ev_s1,
	output gclp_pkg::div_t     last
);

	gclp_pkg::div_t  div_s [0:gclp_pkg::DIV_STAGES];
	gclp_pkg::div_t  step_d [1:gclp_pkg::DIV_STAGES];
	gclp_pkg::div_t  pre_d;
	gclp_pkg::pow_t  p;
	gclp_pkg::num_t  num;
	gclp_pkg::num_t  thr;
	gclp_pkg::cmd_t  cmd;

	function automatic gclp_pkg::div_t div_step(input gclp_pkg::div_t a, input int top);
		gclp_pkg::div_t r;
		gclp_pkg::rem_t sh;
		r = a;
		for (int j = 0; j < gclp_pkg::BPS; j++) begin
			sh = gclp_pkg::rem_t'(r.p) << (top - j);
			if (r.rem >= sh) begin
				r.rem = r.rem - sh;
				r.quo = {r.quo[gclp_pkg::VAL_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[gclp_pkg::VAL_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	// Dividend is accum * 2^FRAC_BITS plus half the divisor, so the quotient rounds.
	always_comb begin
		p   = gclp_pkg::pow10(ev_s1.frac);
		num = (gclp_pkg::num_t'(ev_s1.accum) << gclp_pkg::FRAC_BITS) + gclp_pkg::num_t'(p >> 1);
		thr = (gclp_pkg::num_t'(p) << (gclp_pkg::VAL_W - 1)) +
			(ev_s1.neg ? gclp_pkg::num_t'(p) : '0);
		if (ev_s1.neg) begin
			cmd = (ev_s1.accum > gclp_pkg::acc_t'(gclp_pkg::CMD_MIN)) ? gclp_pkg::CMD_MIN :
				gclp_pkg::cmd_t'(-ev_s1.accum[gclp_pkg::CMD_W-1:0]);
		end else begin
			cmd = (ev_s1.accum > gclp_pkg::acc_t'(gclp_pkg::CMD_MAX)) ? gclp_pkg::CMD_MAX :
				ev_s1.accum[gclp_pkg::CMD_W-1:0];
		end
		pre_d.vld         = ev_s1.vld;
		pre_d.commit      = ev_s1.commit;
		pre_d.eol         = ev_s1.eol;
		pre_d.slot        = ev_s1.slot;
		pre_d.neg         = ev_s1.neg;
		pre_d.sat         = (num >= thr);
		pre_d.cmd         = cmd;
		pre_d.rem         = gclp_pkg::rem_t'(num);
		pre_d.quo         = '0;
		pre_d.p           = p;
		pre_d.letter_ok   = ev_s1.letter_ok;
		pre_d.letter_code = ev_s1.letter_code;
	end

	always_comb begin
		for (int k = 1; k <= gclp_pkg::DIV_STAGES; k++) begin
			step_d[k] = div_step(div_s[k-1], gclp_pkg::VAL_W - 1 - (k - 1) * gclp_pkg::BPS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= gclp_pkg::DIV_STAGES; k++) begin
				div_s[k] <= '0;
			end
		end else if (adv) begin
			div_s[0] <= pre_d;
			for (int k = 1; k <= gclp_pkg::DIV_STAGES; k++) begin
				div_s[k] <= step_d[k];
			end
		end
	end

	assign last = div_s[gclp_pkg::DIV_STAGES];

endmodule

`default_nettype wire

// File: sv/gclp_assemble.sv
// Result assembly: per-line word value registers, the finished-line record and a
// two-entry result queue feeding the output channel. Depends on gclp_pkg, gclp_if.
`default_nettype none

module gclp_assemble (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  gclp_pkg::div_t     last,
	output logic               adv,
	gclp_res_if.source         res
);

	gclp_pkg::val_t   word_q [gclp_pkg::NSLOT];
	gclp_pkg::val_t   word_n [gclp_pkg::NSLOT];
	gclp_pkg::mask_t  present_q, present_n;
	gclp_pkg::cmd_t   cmd_q, cmd_n;
	gclp_pkg::val_t   val;
	logic             take;
	logic             wr;
	logic             push;
	logic             pop;
	logic             full;
	gclp_pkg::res_t   res_d;
	gclp_pkg::res_t   head;
	gclp_pkg::res_t   fifo_q [gclp_pkg::RES_DEPTH];
	logic [gclp_pkg::RES_AW-1:0] wp_q, rp_q;
	gclp_pkg::rcnt_t  cnt_q;

	assign full = (cnt_q == gclp_pkg::rcnt_t'(gclp_pkg::RES_DEPTH));
	assign adv  = !(last.vld && last.eol && full);
	assign take = last.vld && adv;
	assign wr   = take && last.commit;
	assign push = take && last.eol;
	assign pop  = res.valid && res.ready;

	always_comb begin
		if (last.sat) begin
			val = last.neg ? gclp_pkg::VAL_MIN : gclp_pkg::VAL_MAX;
		end else begin
			val = last.neg ? -last.quo : last.quo;
		end
	end

	always_comb begin
		for (int k = 0; k < gclp_pkg::NSLOT; k++) begin
			word_n[k] = (wr && last.slot == gclp_pkg::slot_t'(k)) ? val : word_q[k];
		end
		for (int k = 0; k < gclp_pkg::MASK_W; k++) begin
			present_n[k] = present_q[k] | (wr && last.slot == gclp_pkg::slot_t'(k));
		end
		cmd_n = (wr && last.slot == gclp_pkg::SLOT_CMD) ? last.cmd : cmd_q;
	end

	always_comb begin
		res_d.accepted   = last.letter_ok;
		res_d.cmd_letter = last.letter_code;
		res_d.cmd_number = cmd_n;
		res_d.given_mask = present_n;
		res_d.x_value    = word_n[gclp_pkg::SLOT_X];
		res_d.y_value    = word_n[gclp_pkg::SLOT_Y];
		res_d.z_value    = word_n[gclp_pkg::SLOT_Z];
		res_d.e_value    = word_n[gclp_pkg::SLOT_E];
		res_d.feed_value = word_n[gclp_pkg::SLOT_F];
		res_d.tool_value = word_n[gclp_pkg::SLOT_T];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < gclp_pkg::NSLOT; k++) begin
				word_q[k] <= '0;
			end
			present_q <= '0;
			cmd_q     <= '0;
		end else if (take) begin
			if (last.eol) begin
				for (int k = 0; k < gclp_pkg::NSLOT; k++) begin
					word_q[k] <= '0;
				end
				present_q <= '0;
				cmd_q     <= '0;
			end else begin
				word_q    <= word_n;
				present_q <= present_n;
				cmd_q     <= cmd_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head           = fifo_q[rp_q];
	assign res.valid      = (cnt_q != '0);
	assign res.accepted   = head.accepted;
	assign res.cmd_letter = head.cmd_letter;
	assign res.cmd_number = head.cmd_number;
	assign res.given_mask = head.given_mask;
	assign res.x_value    = head.x_value;
	assign res.y_value    = head.y_value;
	assign res.z_value    = head.z_value;
	assign res.e_value    = head.e_value;
	assign res.feed_value = head.feed_value;
	assign res.tool_value = head.tool_value;

endmodule

`default_nettype wire

// File: sv/gcode_line_field_parser.sv
// G-code line field parser, top level.
// Characters enter on the chr channel, one item per cycle at most; every item
// with valid and ready high at a rising edge of clk is taken.
// A line ends at a newline or carriage return. A non-empty line gives one item
// on the res channel: accept flag, command letter and number, the given mask
// and six Q16.16 word values. An empty line gives nothing.
// Throughput is one character per cycle while chr.ready is high. A line's result
// passes through the parser's event register, the conversion set-up register and
// the stages of the pipelined divider that turns each number into fixed point
// (four quotient bits per stage), then is written into the queue that drives res.
// Results wait in a two-entry queue. While res.ready is low, characters keep
// flowing until the queue is full and another line end reaches the pipeline's
// end; then chr.ready drops and the whole pipeline holds until a result leaves.
// Asynchronous reset (arst_n low) empties the pipeline and queue and puts the
// parser at the start of a line.
// Depends on gclp_pkg, gclp_if, gclp_parser, gclp_convert and gclp_assemble.
`default_nettype none

module gcode_line_field_parser (
	input  wire logic   clk,
	input  wire logic   arst_n,
	gclp_char_if.sink   chr,
	gclp_res_if.source  res
);

	logic            adv;
	gclp_pkg::ev_t   ev_s1;
	gclp_pkg::div_t  last;

	gclp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.chr    (chr),
		.adv    (adv),
		.ev_s1  (ev_s1)
	);

	gclp_convert u_convert (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ev_s1  (ev_s1),
		.last   (last)
	);

	gclp_assemble u_assemble (
		.clk    (clk),
		.arst_n (arst_n),
		.last   (last),
		.adv    (adv),
		.res    (res)
	);

endmodule

`default_nettype wire
